>>> src/bsw_pkg.sv
`default_nettype none
package bsw_pkg;

    // recovery reason codes
    localparam logic [2:0] RSN_CTRL   = 3'd0;
    localparam logic [2:0] RSN_HW     = 3'd1;
    localparam logic [2:0] RSN_BUSY   = 3'd2;
    localparam logic [2:0] RSN_LOW    = 3'd3;
    localparam logic [2:0] RSN_REPLY  = 3'd4;
    localparam logic [2:0] RSN_ARM    = 3'd5;
    localparam logic [2:0] RSN_SILENT = 3'd6;
    localparam logic [2:0] RSN_BAD    = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_STUCK_TIMEOUT   = 3'd0;
    localparam logic [2:0] CFG_REPLY_TIMEOUT   = 3'd1;
    localparam logic [2:0] CFG_BUSY_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_LINE_LOW_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_COOLDOWN        = 3'd4;
    localparam logic [2:0] CFG_SILENCE_RECOVER = 3'd5;
    localparam logic [2:0] CFG_SILENCE_RESET   = 3'd6;
    localparam logic [2:0] CFG_BURST_WINDOW    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [15:0] DEF_STUCK_TIMEOUT   = 16'd50;
    localparam logic [15:0] DEF_REPLY_TIMEOUT   = 16'd50;
    localparam logic [15:0] DEF_BUSY_LIMIT      = 16'd50;
    localparam logic [15:0] DEF_LINE_LOW_LIMIT  = 16'd50;
    localparam logic [15:0] DEF_COOLDOWN        = 16'd20;
    localparam logic [31:0] DEF_SILENCE_RECOVER = 32'd360000;
    localparam logic [31:0] DEF_SILENCE_RESET   = 32'd720000;
    localparam logic [31:0] DEF_BURST_WINDOW    = 32'd10000;

    localparam int unsigned BURST_LIMIT_DEF = 6;
    localparam logic [7:0]  WCNT_MAX        = 8'd255;

    typedef struct packed {
        logic       hw_error;
        logic       ctrl_ready;
        logic       receive_armed;
        logic       reply_busy;
        logic       bus_busy;
        logic       clock_level;
        logic       data_level;
        logic       activity_event;
        logic       valid_frame_event;
        logic       reply_start_event;
        logic       request_event;
        logic [2:0] request_reason;
    } t_item;

    typedef struct packed {
        logic       recovery_start;
        logic [2:0] recovery_reason;
        logic       system_reset;
        logic       request_waiting;
    } t_result;

    typedef struct packed {
        logic [15:0] stuck_timeout;
        logic [15:0] reply_timeout;
        logic [15:0] busy_limit;
        logic [15:0] line_low_limit;
        logic [15:0] cooldown;
        logic [31:0] silence_recover;
        logic [31:0] silence_reset;
        logic [31:0] burst_window;
    } t_cfg;

endpackage
`default_nettype wire

>>> src/bsw_in_if.sv
`default_nettype none
interface bsw_in_if;
    logic       valid;
    logic       ready;
    logic       hw_error;
    logic       ctrl_ready;
    logic       receive_armed;
    logic       reply_busy;
    logic       bus_busy;
    logic       clock_level;
    logic       data_level;
    logic       activity_event;
    logic       valid_frame_event;
    logic       reply_start_event;
    logic       request_event;
    logic [2:0] request_reason;

    modport source (
        output valid, hw_error, ctrl_ready, receive_armed, reply_busy, bus_busy,
               clock_level, data_level, activity_event, valid_frame_event,
               reply_start_event, request_event, request_reason,
        input  ready
    );
    modport sink (
        input  valid, hw_error, ctrl_ready, receive_armed, reply_busy, bus_busy,
               clock_level, data_level, activity_event, valid_frame_event,
               reply_start_event, request_event, request_reason,
        output ready
    );
endinterface
`default_nettype wire

>>> src/bsw_out_if.sv
`default_nettype none
interface bsw_out_if;
    logic       valid;
    logic       ready;
    logic       recovery_start;
    logic [2:0] recovery_reason;
    logic       system_reset;
    logic       request_waiting;

    modport source (
        output valid, recovery_start, recovery_reason, system_reset, request_waiting,
        input  ready
    );
    modport sink (
        input  valid, recovery_start, recovery_reason, system_reset, request_waiting,
        output ready
    );
endinterface
`default_nettype wire

>>> src/bsw_core.sv
`default_nettype none
module bsw_core #(
    parameter int unsigned BURST_LIMIT = bsw_pkg::BURST_LIMIT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire bsw_pkg::t_item   i_item,
    input  wire bsw_pkg::t_cfg    i_cfg,
    output bsw_pkg::t_result      o_result
);
    import bsw_pkg::*;

    localparam logic [7:0] LIMIT = 8'(BURST_LIMIT);

    logic [31:0] r_tick, n_tick;
    logic [31:0] r_last_activity, n_last_activity;
    logic [31:0] r_last_valid, n_last_valid;
    logic [31:0] r_reply_start, n_reply_start;
    logic [31:0] r_busy_since, n_busy_since;
    logic [31:0] r_low_since, n_low_since;
    logic [31:0] r_last_recovery, n_last_recovery;
    logic [31:0] r_window_start, n_window_start;
    logic        r_busy_timing, n_busy_timing;
    logic        r_low_timing, n_low_timing;
    logic        r_silence_armed, n_silence_armed;
    logic        r_pending, n_pending;
    logic [2:0]  r_pending_reason, n_pending_reason;
    logic [7:0]  r_window_count, n_window_count;

    logic        line_low;
    logic        sil_reset;
    logic        sys_reset;
    logic        rec_start;
    logic [2:0]  rec_reason;
    logic [31:0] silence_age;

    always_comb begin
        n_tick           = r_tick;
        n_last_activity  = r_last_activity;
        n_last_valid     = r_last_valid;
        n_reply_start    = r_reply_start;
        n_busy_since     = r_busy_since;
        n_low_since      = r_low_since;
        n_last_recovery  = r_last_recovery;
        n_window_start   = r_window_start;
        n_busy_timing    = r_busy_timing;
        n_low_timing     = r_low_timing;
        n_silence_armed  = r_silence_armed;
        n_pending        = r_pending;
        n_pending_reason = r_pending_reason;
        n_window_count   = r_window_count;
        sil_reset        = 1'b0;
        sys_reset        = 1'b0;
        rec_start        = 1'b0;
        rec_reason       = RSN_CTRL;
        line_low         = !i_item.clock_level || !i_item.data_level;

        // events of this tick
        if (i_item.activity_event) begin
            n_last_activity = r_tick;
        end
        if (i_item.valid_frame_event) begin
            n_last_activity = r_tick;
            n_last_valid    = r_tick;
            n_silence_armed = 1'b0;
        end
        if (i_item.reply_start_event) begin
            n_reply_start   = r_tick;
            n_last_activity = r_tick;
        end
        if (i_item.request_event) begin
            n_pending        = 1'b1;
            n_pending_reason = (i_item.request_reason == RSN_BAD) ? RSN_SILENT
                                                                   : i_item.request_reason;
        end

        silence_age = r_tick - n_last_valid;

        // checks in priority order; the first three end the pass
        if (i_item.hw_error) begin
            n_pending        = 1'b1;
            n_pending_reason = RSN_HW;
        end else if (!i_item.ctrl_ready && !i_item.receive_armed && !i_item.reply_busy) begin
            if ((r_tick - n_last_activity) >= {16'd0, i_cfg.stuck_timeout}) begin
                n_pending        = 1'b1;
                n_pending_reason = RSN_CTRL;
            end
        end else if (i_item.reply_busy &&
                     (r_tick - n_reply_start) >= {16'd0, i_cfg.reply_timeout}) begin
            n_pending        = 1'b1;
            n_pending_reason = RSN_REPLY;
        end else begin
            if (i_item.bus_busy) begin
                if (!r_busy_timing) begin
                    n_busy_timing = 1'b1;
                    n_busy_since  = r_tick;
                end else if ((r_tick - r_busy_since) >= {16'd0, i_cfg.busy_limit}) begin
                    n_pending        = 1'b1;
                    n_pending_reason = RSN_BUSY;
                end
            end else begin
                n_busy_timing = 1'b0;
            end
            if (line_low) begin
                if (!r_low_timing) begin
                    n_low_timing = 1'b1;
                    n_low_since  = r_tick;
                end else if ((r_tick - r_low_since) >= {16'd0, i_cfg.line_low_limit}) begin
                    n_pending        = 1'b1;
                    n_pending_reason = RSN_LOW;
                end
            end else begin
                n_low_timing = 1'b0;
            end
            if (silence_age >= i_cfg.silence_reset) begin
                sil_reset = 1'b1;
            end else if (silence_age >= i_cfg.silence_recover && !n_silence_armed) begin
                n_silence_armed  = 1'b1;
                n_pending        = 1'b1;
                n_pending_reason = RSN_SILENT;
            end
        end

        if (sil_reset) begin
            sys_reset  = 1'b1;
            rec_reason = RSN_SILENT;
        end else if (n_pending &&
                     (r_tick - r_last_recovery) >= {16'd0, i_cfg.cooldown}) begin
            n_pending       = 1'b0;
            n_last_recovery = r_tick;
            rec_reason      = n_pending_reason;
            if ((r_tick - r_window_start) > i_cfg.burst_window) begin
                n_window_start = r_tick;
                n_window_count = '0;
            end
            if (n_window_count < WCNT_MAX) begin
                n_window_count = n_window_count + 8'd1;
            end
            if (n_window_count >= LIMIT) begin
                sys_reset = 1'b1;
            end else begin
                rec_start       = 1'b1;
                n_busy_timing   = 1'b0;
                n_low_timing    = 1'b0;
                n_last_activity = r_tick;
            end
        end

        if (sys_reset) begin
            n_tick           = '0;
            n_last_activity  = '0;
            n_last_valid     = '0;
            n_reply_start    = '0;
            n_busy_since     = '0;
            n_low_since      = '0;
            n_last_recovery  = '0;
            n_window_start   = '0;
            n_busy_timing    = 1'b0;
            n_low_timing     = 1'b0;
            n_silence_armed  = 1'b0;
            n_pending        = 1'b0;
            n_pending_reason = RSN_CTRL;
            n_window_count   = '0;
        end else begin
            n_tick = r_tick + 32'd1;
        end
    end

    always_comb begin
        o_result.recovery_start  = rec_start;
        o_result.recovery_reason = rec_reason;
        o_result.system_reset    = sys_reset;
        o_result.request_waiting = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick           <= '0;
            r_last_activity  <= '0;
            r_last_valid     <= '0;
            r_reply_start    <= '0;
            r_busy_since     <= '0;
            r_low_since      <= '0;
            r_last_recovery  <= '0;
            r_window_start   <= '0;
            r_busy_timing    <= 1'b0;
            r_low_timing     <= 1'b0;
            r_silence_armed  <= 1'b0;
            r_pending        <= 1'b0;
            r_pending_reason <= RSN_CTRL;
            r_window_count   <= '0;
        end else if (i_en) begin
            r_tick           <= n_tick;
            r_last_activity  <= n_last_activity;
            r_last_valid     <= n_last_valid;
            r_reply_start    <= n_reply_start;
            r_busy_since     <= n_busy_since;
            r_low_since      <= n_low_since;
            r_last_recovery  <= n_last_recovery;
            r_window_start   <= n_window_start;
            r_busy_timing    <= n_busy_timing;
            r_low_timing     <= n_low_timing;
            r_silence_armed  <= n_silence_armed;
            r_pending        <= n_pending;
            r_pending_reason <= n_pending_reason;
            r_window_count   <= n_window_count;
        end
    end

endmodule
`default_nettype wire

>>> src/bus_stuck_watchdog.sv
// Bus stuck watchdog, stepped once per millisecond tick.
// i_item carries one tick word: sampled controller status, both line levels
// and this tick's events. o_result returns exactly one word per tick word:
// recovery_start, recovery_reason, system_reset and request_waiting.
// Both channels use valid/ready; a word moves when both are high.
// The input register holds an accepted word; the check logic then writes the
// result register and the watchdog state together.
// Throughput: one tick word per cycle while o_result.ready is high; one tick's
// state update feeds the next tick's checks through the bsw_core state registers.
// If the receiver stalls, the result register holds its word and the input
// register takes one more word, after which i_item.ready drops.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle,
// to be used only while the block is idle.
// Reset (synchronous, active low) clears the tick count, timestamps, pending
// request and burst window, empties both registers and restores the
// configuration defaults. A system reset result also clears the watchdog
// state but keeps the configuration.
`default_nettype none
module bus_stuck_watchdog #(
    parameter int unsigned BURST_LIMIT = bsw_pkg::BURST_LIMIT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    bsw_in_if.sink                                i_item,
    bsw_out_if.source                             o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [bsw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bsw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bsw_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    t_item   in_word;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_comb begin
        in_word.hw_error          = i_item.hw_error;
        in_word.ctrl_ready        = i_item.ctrl_ready;
        in_word.receive_armed     = i_item.receive_armed;
        in_word.reply_busy        = i_item.reply_busy;
        in_word.bus_busy          = i_item.bus_busy;
        in_word.clock_level       = i_item.clock_level;
        in_word.data_level        = i_item.data_level;
        in_word.activity_event    = i_item.activity_event;
        in_word.valid_frame_event = i_item.valid_frame_event;
        in_word.reply_start_event = i_item.reply_start_event;
        in_word.request_event     = i_item.request_event;
        in_word.request_reason    = i_item.request_reason;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stuck_timeout   <= DEF_STUCK_TIMEOUT;
            r_cfg.reply_timeout   <= DEF_REPLY_TIMEOUT;
            r_cfg.busy_limit      <= DEF_BUSY_LIMIT;
            r_cfg.line_low_limit  <= DEF_LINE_LOW_LIMIT;
            r_cfg.cooldown        <= DEF_COOLDOWN;
            r_cfg.silence_recover <= DEF_SILENCE_RECOVER;
            r_cfg.silence_reset   <= DEF_SILENCE_RESET;
            r_cfg.burst_window    <= DEF_BURST_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STUCK_TIMEOUT:   r_cfg.stuck_timeout   <= i_cfg_data[15:0];
                CFG_REPLY_TIMEOUT:   r_cfg.reply_timeout   <= i_cfg_data[15:0];
                CFG_BUSY_LIMIT:      r_cfg.busy_limit      <= i_cfg_data[15:0];
                CFG_LINE_LOW_LIMIT:  r_cfg.line_low_limit  <= i_cfg_data[15:0];
                CFG_COOLDOWN:        r_cfg.cooldown        <= i_cfg_data[15:0];
                CFG_SILENCE_RECOVER: r_cfg.silence_recover <= i_cfg_data;
                CFG_SILENCE_RESET:   r_cfg.silence_reset   <= i_cfg_data;
                CFG_BURST_WINDOW:    r_cfg.burst_window    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_item <= in_word;
        end
    end

    bsw_core #(
        .BURST_LIMIT (BURST_LIMIT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.recovery_start  = r_out.recovery_start;
    assign o_result.recovery_reason = r_out.recovery_reason;
    assign o_result.system_reset    = r_out.system_reset;
    assign o_result.request_waiting = r_out.request_waiting;

    a_start_xor_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.recovery_start && r_out.system_reset))
        else $error("recovery and system reset in the same word");

    a_reset_clears_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.system_reset |-> !r_out.request_waiting)
        else $error("request still waiting after system reset");

    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("stalled input word lost");

endmodule
`default_nettype wire
